>>> design/ccks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccks_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 8;
   localparam int DAY_W    = 8;
   localparam int HMS_W    = 7;
   localparam int COL_W    = 4;
   localparam int KEY_W    = 5;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 64;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_KEY  = 1'b1;

   localparam logic [KEY_W-1:0] KEY_ROW_TOGGLE = 5'd4;
   localparam logic [KEY_W-1:0] KEY_RIGHT      = 5'd12;
   localparam logic [KEY_W-1:0] KEY_LEFT       = 5'd13;
   localparam logic [KEY_W-1:0] KEY_RUN        = 5'd15;
   localparam logic [KEY_W-1:0] KEY_SETUP      = 5'd16;

   localparam logic [YEAR_W-1:0] YEAR_LAST = 14'd9999;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HMS_W-1:0]   hour;
      logic [HMS_W-1:0]   minute;
      logic [HMS_W-1:0]   second;
      logic               cursor_row;
      logic [COL_W-1:0]   cursor_col;
      logic               running;
   } cal_state_type;

   localparam cal_state_type CAL_RESET = '{
      year:       14'd2001,
      month:      8'd2,
      day:        8'd28,
      hour:       7'd23,
      minute:     7'd59,
      second:     7'd57,
      cursor_row: 1'b0,
      cursor_col: 4'd15,
      running:    1'b0
   };

endpackage

`default_nettype wire

>>> design/ccks_tick.sv
`timescale 1ns / 1ps
`default_nettype none

module ccks_tick (
   input  ccks_pkg::cal_state_type cur,
   output ccks_pkg::cal_state_type nxt
);
   import ccks_pkg::*;

   logic leap;

   function automatic logic long_month(input logic [MONTH_W-1:0] m);
      return m == 8'd1 || m == 8'd3 || m == 8'd5 || m == 8'd7 || m == 8'd8 || m == 8'd10;
   endfunction

   function automatic logic short_month(input logic [MONTH_W-1:0] m);
      return m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11;
   endfunction

   function automatic logic [YEAR_W-1:0] bump_year(input logic [YEAR_W-1:0] y);
      return (y >= YEAR_LAST) ? '0 : y + 14'd1;
   endfunction

   always_comb begin
      nxt  = cur;
      leap = (cur.year[1:0] == 2'd0);

      // validate
      if (nxt.hour > 7'd23) begin
         nxt.hour   = 7'd23;
         nxt.minute = '0;
         nxt.day    = nxt.day + 8'd1;
      end
      if (nxt.month > 8'd12) begin
         if (nxt.day > 8'd31) begin
            nxt.day = 8'd1;
         end
         nxt.month = 8'd1;
         nxt.year  = bump_year(nxt.year);
         leap      = (nxt.year[1:0] == 2'd0);
      end
      if (long_month(nxt.month)) begin
         if (nxt.day > 8'd31) begin
            nxt.day   = 8'd1;
            nxt.month = nxt.month + 8'd1;
         end
      end else if (short_month(nxt.month)) begin
         if (nxt.day > 8'd30) begin
            nxt.day   = 8'd1;
            nxt.month = nxt.month + 8'd1;
         end
      end else if (nxt.month == 8'd2) begin
         if (nxt.day > (leap ? 8'd29 : 8'd28)) begin
            nxt.day   = 8'd1;
            nxt.month = nxt.month + 8'd1;
         end
      end

      // advance
      leap       = (nxt.year[1:0] == 2'd0);
      nxt.second = nxt.second + 7'd1;
      if (nxt.second > 7'd59) begin
         nxt.second = '0;
         nxt.minute = nxt.minute + 7'd1;
      end
      if (nxt.minute > 7'd59) begin
         nxt.minute = '0;
         nxt.hour   = nxt.hour + 7'd1;
      end
      if (nxt.hour > 7'd23) begin
         nxt.hour = '0;
         nxt.day  = nxt.day + 8'd1;
      end
      if (long_month(nxt.month) && nxt.day == 8'd32) begin
         nxt.day   = 8'd1;
         nxt.month = nxt.month + 8'd1;
      end else if (short_month(nxt.month) && nxt.day == 8'd31) begin
         nxt.day   = 8'd1;
         nxt.month = nxt.month + 8'd1;
      end else if (nxt.month == 8'd2 && nxt.day == (leap ? 8'd30 : 8'd29)) begin
         nxt.day   = 8'd1;
         nxt.month = nxt.month + 8'd1;
      end
      if (nxt.month == 8'd12 && nxt.day == 8'd32) begin
         nxt.day   = 8'd1;
         nxt.month = 8'd1;
         nxt.year  = bump_year(nxt.year);
      end
   end

endmodule

`default_nettype wire

>>> design/ccks_key.sv
`timescale 1ns / 1ps
`default_nettype none

module ccks_key (
   input  ccks_pkg::cal_state_type          cur,
   input  logic [ccks_pkg::KEY_W-1:0]       key,
   output ccks_pkg::cal_state_type          nxt
);
   import ccks_pkg::*;

   localparam logic [COL_W-1:0] COL_YEAR_3  = 4'd6;
   localparam logic [COL_W-1:0] COL_YEAR_2  = 4'd7;
   localparam logic [COL_W-1:0] COL_YEAR_1  = 4'd8;
   localparam logic [COL_W-1:0] COL_YEAR_0  = 4'd9;
   localparam logic [COL_W-1:0] COL_MONTH_1 = 4'd11;
   localparam logic [COL_W-1:0] COL_MONTH_0 = 4'd12;
   localparam logic [COL_W-1:0] COL_DAY_1   = 4'd14;
   localparam logic [COL_W-1:0] COL_DAY_0   = 4'd15;
   localparam logic [COL_W-1:0] COL_HOUR_1  = 4'd6;
   localparam logic [COL_W-1:0] COL_HOUR_0  = 4'd7;
   localparam logic [COL_W-1:0] COL_MIN_1   = 4'd9;
   localparam logic [COL_W-1:0] COL_MIN_0   = 4'd10;
   localparam logic [COL_W-1:0] COL_SEC_1   = 4'd12;
   localparam logic [COL_W-1:0] COL_SEC_0   = 4'd13;

   logic              is_digit;
   logic [3:0]        digit;
   logic [YEAR_W-1:0] d14;
   logic [YEAR_W-1:0] y_r1000;
   logic [YEAR_W-1:0] y_r100;
   logic [YEAR_W-1:0] y_r10;

   // remainder of v by step, valid while v stays below seventeen steps
   function automatic logic [YEAR_W-1:0] rem_by(input logic [YEAR_W-1:0] v,
                                                input logic [YEAR_W-1:0] step);
      logic [YEAR_W-1:0] r;
      r = v;
      for (int k = 1; k <= 16; k++) begin
         if (int'(v) >= int'(step) * k) begin
            r = v - YEAR_W'(int'(step) * k);
         end
      end
      return r;
   endfunction

   function automatic logic [YEAR_W-1:0] set_tens(input logic [YEAR_W-1:0] v,
                                                  input logic [YEAR_W-1:0] d);
      logic [YEAR_W-1:0] r100;
      logic [YEAR_W-1:0] r10;
      r100 = rem_by(v, 14'd100);
      r10  = rem_by(r100, 14'd10);
      return v - r100 + d * 14'd10 + r10;
   endfunction

   function automatic logic [YEAR_W-1:0] set_ones(input logic [YEAR_W-1:0] v,
                                                  input logic [YEAR_W-1:0] d);
      logic [YEAR_W-1:0] r10;
      r10 = rem_by(rem_by(v, 14'd100), 14'd10);
      return v - r10 + d;
   endfunction

   always_comb begin
      is_digit = 1'b1;
      case (key)
         5'd1, 5'd2, 5'd3:   digit = key[3:0];
         5'd5, 5'd6, 5'd7:   digit = key[3:0] - 4'd1;
         5'd9, 5'd10, 5'd11: digit = key[3:0] - 4'd2;
         5'd14:              digit = 4'd0;
         default: begin
            digit    = 4'd0;
            is_digit = 1'b0;
         end
      endcase
   end

   assign d14     = {{(YEAR_W-4){1'b0}}, digit};
   assign y_r1000 = rem_by(cur.year, 14'd1000);
   assign y_r100  = rem_by(y_r1000, 14'd100);
   assign y_r10   = rem_by(y_r100, 14'd10);

   always_comb begin
      nxt = cur;
      if (key == KEY_RIGHT) begin
         nxt.cursor_col = cur.cursor_col + 4'd1;
      end else if (key == KEY_LEFT) begin
         nxt.cursor_col = cur.cursor_col - 4'd1;
      end else if (key == KEY_ROW_TOGGLE) begin
         nxt.cursor_row = ~cur.cursor_row;
      end else if (is_digit) begin
         if (cur.cursor_row == 1'b0) begin
            case (cur.cursor_col)
               COL_YEAR_3:  nxt.year = y_r1000 + d14 * 14'd1000;
               COL_YEAR_2:  nxt.year = cur.year - y_r1000 + d14 * 14'd100 + y_r100;
               COL_YEAR_1:  nxt.year = cur.year - y_r100 + d14 * 14'd10 + y_r10;
               COL_YEAR_0:  nxt.year = cur.year - y_r10 + d14;
               COL_MONTH_1: nxt.month = MONTH_W'(set_tens(YEAR_W'(cur.month), d14));
               COL_MONTH_0: nxt.month = MONTH_W'(set_ones(YEAR_W'(cur.month), d14));
               COL_DAY_1:   nxt.day = DAY_W'(set_tens(YEAR_W'(cur.day), d14));
               COL_DAY_0:   nxt.day = DAY_W'(set_ones(YEAR_W'(cur.day), d14));
               default:     nxt = cur;
            endcase
         end else begin
            case (cur.cursor_col)
               COL_HOUR_1: nxt.hour = HMS_W'(set_tens(YEAR_W'(cur.hour), d14));
               COL_HOUR_0: nxt.hour = HMS_W'(set_ones(YEAR_W'(cur.hour), d14));
               COL_MIN_1:  nxt.minute = HMS_W'(set_tens(YEAR_W'(cur.minute), d14));
               COL_MIN_0:  nxt.minute = HMS_W'(set_ones(YEAR_W'(cur.minute), d14));
               COL_SEC_1:  nxt.second = HMS_W'(set_tens(YEAR_W'(cur.second), d14));
               COL_SEC_0:  nxt.second = HMS_W'(set_ones(YEAR_W'(cur.second), d14));
               default:    nxt = cur;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

>>> design/calendar_clock_with_keypad_setup_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                     contents
// req_      in         tvalid tready tdata tuser  one tick or key request
// rsp_      out        tvalid tready tdata        clock and cursor after update
//
// One request per cycle is sustained while rsp_tready stays high; a taken
// request loads the input register, and the update then loads the result
// register, which raises rsp_tvalid.
// The update is one pass through the tick and key logic between the two.
// Reset clears both valid flags and loads the reset date and time, setup mode.
// A stalled result holds the result register; the input register still
// takes one more request, then req_tready drops.

module calendar_clock_with_keypad_setup_unit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [ccks_pkg::REQ_DATA_W-1:0]    req_tdata,  // [4:0] key_code
   input  wire                                req_tuser,  // [0] operation
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [13:0] year_now, [21:14] month_now, [29:22] day_now, [36:30] hour_now,
   // [43:37] minute_now, [50:44] second_now, [51] cursor_row,
   // [55:52] cursor_column, [56] running
   output logic [ccks_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import ccks_pkg::*;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_op_ff;
   logic [KEY_W-1:0]      in_key_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   cal_state_type         state_ff;
   cal_state_type         state_in;
   cal_state_type         tick_next;
   cal_state_type         key_next;
   logic                  out_free;
   logic                  fire;
   logic                  take;

   ccks_tick u_tick (
      .cur (state_ff),
      .nxt (tick_next)
   );

   ccks_key u_key (
      .cur (state_ff),
      .key (in_key_ff),
      .nxt (key_next)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      if (in_op_ff == OP_TICK) begin
         if (state_ff.running) begin
            state_in = tick_next;
         end
      end else if (in_key_ff == KEY_RUN) begin
         state_in.running = 1'b1;
      end else if (in_key_ff == KEY_SETUP) begin
         state_in.running = 1'b0;
      end else if (!state_ff.running) begin
         state_in = key_next;
      end
   end

   assign in_valid_in  = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = {7'd0, state_in.running, state_in.cursor_col, state_in.cursor_row,
                          state_in.second, state_in.minute, state_in.hour,
                          state_in.day, state_in.month, state_in.year};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= CAL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff  <= req_tuser;
         in_key_ff <= req_tdata[KEY_W-1:0];
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_year_range : assert property (@(posedge clock) disable iff (reset)
      state_ff.year <= YEAR_LAST)
      else $error("year out of range");

   a_setup_tick_frozen : assert property (@(posedge clock) disable iff (reset)
      fire && in_op_ff == OP_TICK && !state_ff.running |=> state_ff == $past(state_ff))
      else $error("tick changed state in setup mode");

   a_run_cursor_fixed : assert property (@(posedge clock) disable iff (reset)
      fire && state_ff.running |=>
         state_ff.cursor_col == $past(state_ff.cursor_col) &&
         state_ff.cursor_row == $past(state_ff.cursor_row))
      else $error("cursor moved in run mode");

   a_input_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && state_ff == $past(state_ff))
      else $error("request lost or state moved while blocked");

endmodule

`default_nettype wire

>>> verif/calendar_clock_with_keypad_setup_unit_tb.sv
`timescale 1ns / 1ps

module calendar_clock_with_keypad_setup_unit_tb;
   import ccks_pkg::*;

   localparam logic [KEY_W-1:0] KEY_NONE       = 5'd0;
   localparam logic [KEY_W-1:0] KEY_SPARE      = 5'd8;
   localparam logic [KEY_W-1:0] KEY_DIGIT_ZERO = 5'd14;
   localparam logic [KEY_W-1:0] KEY_TOP        = 5'd31;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int LONG_HOLD      = 60;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
   } key_event_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;

   key_event_type key_tick_queue[$];
   cal_state_type clock_readouts_due[$];
   cal_state_type model_clock;
   cal_state_type gen_clock;
   logic          req_taken = 1'b0;
   int            accepted_count = 0;
   int            error_count = 0;
   int            idle_cycles = 0;
   int            send_gap = 0;
   int            hold_left = 0;
   logic          long_hold_done = 1'b0;

   calendar_clock_with_keypad_setup_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int days_in(int month, int year);
      case (month)
         1, 3, 5, 7, 8, 10: return 31;
         4, 6, 9, 11:       return 30;
         2:                 return (year % 4 == 0) ? 29 : 28;
         default:           return 0;
      endcase
   endfunction

   function automatic int year_after(int year);
      return (year >= YEAR_LAST) ? 0 : year + 1;
   endfunction

   function automatic int with_tens(int v, int d);
      return v - (v % 100) + d * 10 + (v % 10);
   endfunction

   function automatic int with_ones(int v, int d);
      return v - (v % 10) + d;
   endfunction

   function automatic logic [KEY_W-1:0] key_of_digit(int d);
      if (d == 0) return KEY_DIGIT_ZERO;
      else if (d <= 3) return KEY_W'(d);
      else if (d <= 6) return KEY_W'(d + 1);
      else return KEY_W'(d + 2);
   endfunction

   function automatic cal_state_type calendar_after(cal_state_type s, logic op,
                                                   logic [KEY_W-1:0] key);
      int digit;
      int len;
      int yr;
      digit = -1;
      if (op == OP_TICK) begin
         if (s.running) begin
            if (s.hour > 23) begin
               s.hour = 7'd23;
               s.minute = 7'd0;
               s.day = s.day + 8'd1;
            end
            if (s.month > 12) begin
               if (s.day > 31) s.day = 8'd1;
               s.month = 8'd1;
               s.year = YEAR_W'(year_after(s.year));
            end
            len = days_in(s.month, s.year);
            if (len != 0 && s.day > len) begin
               s.day = 8'd1;
               s.month = s.month + 8'd1;
            end
            len = days_in(s.month, s.year);
            s.second = s.second + 7'd1;
            if (s.second > 59) begin
               s.second = 7'd0;
               s.minute = s.minute + 7'd1;
            end
            if (s.minute > 59) begin
               s.minute = 7'd0;
               s.hour = s.hour + 7'd1;
            end
            if (s.hour > 23) begin
               s.hour = 7'd0;
               s.day = s.day + 8'd1;
            end
            if (len != 0 && s.day == len + 1) begin
               s.day = 8'd1;
               s.month = s.month + 8'd1;
            end
            if (s.month == 12 && s.day == 32) begin
               s.day = 8'd1;
               s.month = 8'd1;
               s.year = YEAR_W'(year_after(s.year));
            end
         end
      end else if (key == KEY_RUN) begin
         s.running = 1'b1;
      end else if (key == KEY_SETUP) begin
         s.running = 1'b0;
      end else if (!s.running) begin
         if (key == KEY_RIGHT) begin
            s.cursor_col = s.cursor_col + 4'd1;
         end else if (key == KEY_LEFT) begin
            s.cursor_col = s.cursor_col - 4'd1;
         end else if (key == KEY_ROW_TOGGLE) begin
            s.cursor_row = ~s.cursor_row;
         end else begin
            for (int i = 0; i < 10; i++) begin
               if (key == key_of_digit(i)) digit = i;
            end
         end
         if (digit >= 0) begin
            yr = s.year;
            if (!s.cursor_row) begin
               case (s.cursor_col)
                  6:  s.year = YEAR_W'((yr % 1000) + digit * 1000);
                  7:  s.year = YEAR_W'(yr - (yr % 1000) + digit * 100 + (yr % 100));
                  8:  s.year = YEAR_W'(with_tens(yr, digit));
                  9:  s.year = YEAR_W'(with_ones(yr, digit));
                  11: s.month = MONTH_W'(with_tens(s.month, digit));
                  12: s.month = MONTH_W'(with_ones(s.month, digit));
                  14: s.day = DAY_W'(with_tens(s.day, digit));
                  15: s.day = DAY_W'(with_ones(s.day, digit));
                  default: ;
               endcase
            end else begin
               case (s.cursor_col)
                  6:  s.hour = HMS_W'(with_tens(s.hour, digit));
                  7:  s.hour = HMS_W'(with_ones(s.hour, digit));
                  9:  s.minute = HMS_W'(with_tens(s.minute, digit));
                  10: s.minute = HMS_W'(with_ones(s.minute, digit));
                  12: s.second = HMS_W'(with_tens(s.second, digit));
                  13: s.second = HMS_W'(with_ones(s.second, digit));
                  default: ;
               endcase
            end
         end
      end
      return s;
   endfunction

   function automatic logic idling_on();
      return key_tick_queue.size() >= 80 && (accepted_count / 64) % 3 != 2;
   endfunction

   task automatic push_request(logic op, logic [KEY_W-1:0] key);
      key_tick_queue.push_back('{op: op, key: key});
      gen_clock = calendar_after(gen_clock, op, key);
   endtask

   task automatic press(logic [KEY_W-1:0] key);
      push_request(OP_KEY, key);
   endtask

   task automatic move_cursor(logic row, int col);
      if (gen_clock.cursor_row != row) press(KEY_ROW_TOGGLE);
      while (gen_clock.cursor_col != col) begin
         if (((col - gen_clock.cursor_col) & 15) <= 8) press(KEY_RIGHT);
         else press(KEY_LEFT);
      end
   endtask

   task automatic type_number(logic row, int col, int n, int value);
      int div;
      for (int i = 0; i < n; i++) begin
         div = 1;
         repeat (n - 1 - i) div = div * 10;
         move_cursor(row, col + i);
         press(key_of_digit((value / div) % 10));
      end
   endtask

   task automatic report_mismatch(string what);
      $display("%0t ERROR %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   always @(negedge clock) begin : drive_requests
      key_event_type item;
      logic send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         send = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (idling_on() && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 10) - 1;
         end else if (key_tick_queue.size() != 0) begin
            send = 1'b1;
         end
         if (send) begin
            item = key_tick_queue.pop_front();
            req_tuser <= item.op;
            req_tdata <= {{(REQ_DATA_W - KEY_W){1'b0}}, item.key};
         end
         req_tvalid <= send;
      end
   end

   always @(negedge clock) begin : drive_readout_ready
      if (!long_hold_done && accepted_count >= 150) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_readouts
      cal_state_type want;
      logic rsp_taken;
      if (reset) begin
         model_clock = CAL_RESET;
         req_taken = 1'b0;
         idle_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         rsp_taken = rsp_tvalid && rsp_tready;
         if (req_taken) begin
            model_clock = calendar_after(model_clock, req_tuser,
                                         req_tdata[KEY_W-1:0]);
            clock_readouts_due.push_back(model_clock);
            accepted_count++;
         end
         if (rsp_taken) begin
            if (clock_readouts_due.size() == 0) begin
               report_mismatch($sformatf("readout with none pending: %h", rsp_tdata));
            end else begin
               want = clock_readouts_due.pop_front();
               check_field("year", rsp_tdata[13:0], want.year);
               check_field("month", rsp_tdata[21:14], want.month);
               check_field("day", rsp_tdata[29:22], want.day);
               check_field("hour", rsp_tdata[36:30], want.hour);
               check_field("minute", rsp_tdata[43:37], want.minute);
               check_field("second", rsp_tdata[50:44], want.second);
               check_field("cursor_row", rsp_tdata[51], want.cursor_row);
               check_field("cursor_column", rsp_tdata[55:52], want.cursor_col);
               check_field("running", rsp_tdata[56], want.running);
               check_field("padding", rsp_tdata[63:57], 0);
            end
         end
         if (req_taken || rsp_taken) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : run_test
      int kind;
      int month;
      gen_clock = CAL_RESET;

      // setup-mode corner cases from reset
      push_request(OP_TICK, KEY_TOP);
      press(KEY_NONE);
      press(KEY_SPARE);
      press(KEY_TOP);
      press(KEY_RIGHT);
      press(KEY_LEFT);
      press(KEY_ROW_TOGGLE);
      press(KEY_DIGIT_ZERO);
      press(KEY_ROW_TOGGLE);
      press(KEY_LEFT);
      press(KEY_DIGIT_ZERO);
      press(key_of_digit(8));
      press(KEY_SETUP);
      press(KEY_RUN);
      press(KEY_RIGHT);
      press(key_of_digit(9));
      press(KEY_SPARE);
      repeat (4) push_request(OP_TICK, KEY_NONE);
      press(KEY_RUN);
      press(KEY_SETUP);
      push_request(OP_TICK, KEY_NONE);

      while (key_tick_queue.size() < 590) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // load a date and time near a rollover, then run
            press(KEY_SETUP);
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 3))
                  0: type_number(1'b0, 6, 4, YEAR_LAST);
                  1: type_number(1'b0, 6, 4, $urandom_range(0, 2499) * 4);
                  default: type_number(1'b0, 6, 4, $urandom_range(0, 9999));
               endcase
            end
            if ($urandom_range(0, 2) != 0) begin
               month = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                   : $urandom_range(0, 14);
               type_number(1'b0, 11, 2, month);
            end
            if ($urandom_range(0, 2) != 0)
               type_number(1'b0, 14, 2, $urandom_range(0, 1) ? $urandom_range(26, 33)
                                                              : $urandom_range(0, 99));
            if ($urandom_range(0, 2) != 0)
               type_number(1'b1, 6, 2, $urandom_range(0, 2) ? 23 : $urandom_range(0, 99));
            if ($urandom_range(0, 2) != 0)
               type_number(1'b1, 9, 2, $urandom_range(0, 2) ? 59 : $urandom_range(0, 99));
            if ($urandom_range(0, 2) != 0)
               type_number(1'b1, 12, 2, $urandom_range(0, 2) ? $urandom_range(50, 59)
                                                             : $urandom_range(0, 99));
            press(KEY_RUN);
            repeat ($urandom_range(1, 15)) begin
               if ($urandom_range(0, 7) == 0) press(KEY_W'($urandom_range(0, 14)));
               push_request(OP_TICK, KEY_W'($urandom_range(0, 31)));
            end
         end else if (kind == 6) begin
            repeat ($urandom_range(5, 15)) push_request(1'($urandom_range(0, 1)),
                                                        KEY_W'($urandom_range(0, 31)));
         end else if (kind == 7) begin
            press(KEY_SETUP);
            repeat ($urandom_range(5, 20)) begin
               case ($urandom_range(0, 4))
                  0: press(KEY_RIGHT);
                  1: press(KEY_LEFT);
                  2: press(KEY_ROW_TOGGLE);
                  default: press(key_of_digit($urandom_range(0, 9)));
               endcase
            end
         end else if (kind == 8) begin
            press(KEY_RUN);
            repeat ($urandom_range(20, 60))
               push_request(OP_TICK, KEY_W'($urandom_range(0, 31)));
         end else begin
            // abandon an edit part way, tick while frozen
            press(KEY_SETUP);
            move_cursor(1'($urandom_range(0, 1)), $urandom_range(0, 15));
            press(key_of_digit($urandom_range(0, 9)));
            repeat ($urandom_range(1, 5))
               push_request(OP_TICK, KEY_W'($urandom_range(0, 31)));
            if ($urandom_range(0, 1)) press(KEY_RUN);
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (key_tick_queue.size() != 0 || req_tvalid || clock_readouts_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ccks_pkg.sv
design/ccks_tick.sv
design/ccks_key.sv
design/calendar_clock_with_keypad_setup_unit.sv
verif/calendar_clock_with_keypad_setup_unit_tb.sv
